FILE: hdl/amemd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amemd_pkg: shared types and constants for the motion detector
// Payload structs, register indexes, sequencer states, widths of the
// bit-serial datapath and the per-range sensitivity table.
// ----------------------------------------------------------------------------
package amemd_pkg;

  // Field widths
  localparam int unsigned AccelW      = 16;
  localparam int unsigned GW          = 21;
  localparam int unsigned WeightW     = 8;
  localparam int unsigned RangeW      = 2;
  localparam int unsigned FracBitsDef = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;

  // Datapath widths
  localparam int unsigned SqW   = 2 * AccelW;      // one squared axis, and their sum
  localparam int unsigned RtW   = (SqW + 30) / 2;  // root of sum scaled by 2^30
  localparam int unsigned SensW = 29;              // sensitivity in 1e-12 g
  localparam int unsigned PicoW = 40;

  localparam logic [PicoW-1:0] Pico = 40'd1000000000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RANGE  = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_MUL,
    ST_CHK,
    ST_QDIV,
    ST_EADD,
    ST_EDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [GW-1:0] magnitude_g;
    logic [GW-1:0] averaged_g;
    logic          motion_detected;
  } out_t;

  // Sensitivity per count for each full-scale range, in 1e-12 g
  function automatic logic [SensW-1:0] sens_pg(input logic [RangeW-1:0] sel);
    logic [SensW-1:0] v;
    case (sel)
      2'd0:    v = 29'd58688890;
      2'd1:    v = 29'd117370892;
      2'd2:    v = 29'd234741784;
      2'd3:    v = 29'd469483568;
      default: v = 29'd469483568;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/accel_magnitude_ema_motion_detect_top.sv
`timescale 1ns / 1ps
// Sequencing: the sequencer holds one frame at a time, running the 16-step square,
//   the 31-step root loop, the 29-step shift-add multiply and two 21-step restoring
//   divides before it takes the next frame. Input ready is high only while idle.
// Reset: clears the sequencer, the result valid flag, the above count, loads the
//   running average with 0.9 g and the registers with their reset values.
// ----------------------------------------------------------------------------
// accel_magnitude_ema_motion_detect_top
// Bit-serial accelerometer magnitude, moving average and motion detector.
// ----------------------------------------------------------------------------
module accel_magnitude_ema_motion_detect_top #(
  parameter int unsigned FRAC_BITS = amemd_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  amemd_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output amemd_pkg::out_t                  out_data_o,
  input  logic                             cfg_we_i,
  input  logic [amemd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [amemd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import amemd_pkg::*;

  // Scaling: mag = floor(t * 2^FRAC_BITS / (2^15 * 1e12))
  localparam int unsigned SH   = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int unsigned KSH  = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam int unsigned DVW  = PicoW + KSH;
  localparam logic [DVW-1:0] DIVISOR = DVW'(Pico) << KSH;
  localparam int unsigned TW   = RtW + SensW;
  localparam int unsigned NW   = TW + SH;
  localparam int unsigned NHW  = NW - GW;
  localparam int unsigned CW   = (NHW > DVW) ? NHW : DVW;
  localparam int unsigned REMW = RtW + 2;
  localparam int unsigned EPW  = GW + WeightW;
  localparam int unsigned CNTW = $clog2(RtW);

  // Reset values that follow the fraction width
  localparam logic [GW-1:0] GMAX = '1;
  localparam longint unsigned AVG_RAW = (64'd9 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam longint unsigned THR_RAW = 64'd1 << FRAC_BITS;
  localparam logic [GW-1:0] AVG_RST = (AVG_RAW > 64'(GMAX)) ? GMAX : GW'(AVG_RAW);
  localparam logic [GW-1:0] THR_RST = (THR_RAW > 64'(GMAX)) ? GMAX : GW'(THR_RAW);

  // Control state
  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        above_q, above_d;
  logic [GW-1:0]     avg_q, avg_d;
  logic [RangeW-1:0] range_q;
  logic [WeightW-1:0] weight_q;
  logic [GW-1:0]     thresh_q;

  // Datapath registers
  logic [AccelW-1:0] mcand_q [3];
  logic [SqW-1:0]    sq_q [3];
  logic [EPW-1:0]    ema_p_q;
  logic [SqW-1:0]    s_q;
  logic [REMW-1:0]   rem_q;
  logic [RtW-1:0]    root_q;
  logic [TW-1:0]     prod_q;
  logic              sat_q;
  logic [DVW-1:0]    dr_q;
  logic [GW-1:0]     nlo_q;
  logic [WeightW:0]  er_q;
  logic [GW-1:0]     mag_q;
  out_t              out_q;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              det;
  logic [AccelW-1:0] axis_abs [3];

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Absolute value of each axis
  always_comb begin
    axis_abs[0] = in_data_i.accel_x[AccelW-1] ? AccelW'(-in_data_i.accel_x)
                                              : AccelW'(in_data_i.accel_x);
    axis_abs[1] = in_data_i.accel_y[AccelW-1] ? AccelW'(-in_data_i.accel_y)
                                              : AccelW'(in_data_i.accel_y);
    axis_abs[2] = in_data_i.accel_z[AccelW-1] ? AccelW'(-in_data_i.accel_z)
                                              : AccelW'(in_data_i.accel_z);
  end

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SQR;
      ST_SQR:  if (cnt_q == CNTW'(AccelW - 1)) state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == CNTW'(RtW - 1)) state_d = ST_MUL;
      ST_MUL:  if (cnt_q == CNTW'(SensW - 1)) state_d = ST_CHK;
      ST_CHK:  state_d = ST_QDIV;
      ST_QDIV: if (cnt_q == CNTW'(GW - 1)) state_d = ST_EADD;
      ST_EADD: state_d = ST_EDIV;
      ST_EDIV: if (cnt_q == CNTW'(GW - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, step counter, result load
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_DONE) && out_free;
    cnt_d      = (state_d != state_q) ? '0 : cnt_q + 1'b1;
  end

  // Threshold compare and above count on the new average
  always_comb begin
    logic [1:0] inc;
    inc         = (nlo_q > thresh_q) ? above_q + 2'd1 : 2'd0;
    det         = (inc == 2'd2);
    above_d     = above_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load) begin
      above_d     = det ? 2'd0 : inc;
      avg_d       = nlo_q;
      out_valid_d = 1'b1;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      above_q     <= 2'd0;
      avg_q       <= AVG_RST;
      range_q     <= RangeW'(2);
      weight_q    <= WeightW'(10);
      thresh_q    <= THR_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      above_q     <= above_d;
      avg_q       <= avg_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_RANGE:  range_q  <= cfg_wdata_i[RangeW-1:0];
          REG_WEIGHT: weight_q <= cfg_wdata_i[WeightW-1:0];
          REG_THRESH: thresh_q <= cfg_wdata_i[GW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Bit-serial datapath
  always_ff @(posedge clk_i) begin
    logic [AccelW:0]   lsum;
    logic [GW:0]       esum;
    logic [REMW+1:0]   rtry;
    logic [REMW+1:0]   trial;
    logic [RtW:0]      psum;
    logic [NW-1:0]     nfull;
    logic [NHW-1:0]    ntop;
    logic [DVW:0]      dtry;
    logic [GW-1:0]     magv;
    logic [EPW-1:0]    en;
    logic [WeightW+1:0] etry;
    logic [WeightW+1:0] dvs;
    case (state_q)
      // Latch axis magnitudes and the old average weight
      ST_IDLE: begin
        if (accept) begin
          for (int l = 0; l < 3; l++) begin
            mcand_q[l] <= axis_abs[l];
            sq_q[l]    <= {AccelW'(0), axis_abs[l]};
          end
          ema_p_q <= {GW'(0), weight_q};
        end
      end
      // Square each axis, one multiplier bit a cycle; weight the old average
      ST_SQR: begin
        for (int l = 0; l < 3; l++) begin
          if (sq_q[l][0]) begin
            lsum = {1'b0, sq_q[l][SqW-1:AccelW]} + {1'b0, mcand_q[l]};
            sq_q[l] <= {lsum, sq_q[l][AccelW-1:1]};
          end else begin
            sq_q[l] <= {1'b0, sq_q[l][SqW-1:1]};
          end
        end
        if (cnt_q < CNTW'(WeightW)) begin
          if (ema_p_q[0]) begin
            esum = {1'b0, ema_p_q[EPW-1:WeightW]} + {1'b0, avg_q};
            ema_p_q <= {esum, ema_p_q[WeightW-1:1]};
          end else begin
            ema_p_q <= {1'b0, ema_p_q[EPW-1:1]};
          end
        end
      end
      // Sum of squares feeds the root shift register
      ST_SUM: begin
        s_q    <= sq_q[0] + sq_q[1] + sq_q[2];
        rem_q  <= '0;
        root_q <= '0;
      end
      // Restoring square root, one result bit a cycle
      ST_ROOT: begin
        rtry  = {rem_q, s_q[SqW-1:SqW-2]};
        trial = {2'b00, root_q, 2'b01};
        s_q   <= {s_q[SqW-3:0], 2'b00};
        if (rtry >= trial) begin
          rem_q  <= REMW'(rtry - trial);
          root_q <= {root_q[RtW-2:0], 1'b1};
        end else begin
          rem_q  <= rtry[REMW-1:0];
          root_q <= {root_q[RtW-2:0], 1'b0};
        end
        prod_q <= {RtW'(0), sens_pg(range_q)};
      end
      // Root times sensitivity, one multiplier bit a cycle
      ST_MUL: begin
        if (prod_q[0]) begin
          psum = {1'b0, prod_q[TW-1:SensW]} + {1'b0, root_q};
          prod_q <= {psum, prod_q[SensW-1:1]};
        end else begin
          prod_q <= {1'b0, prod_q[TW-1:1]};
        end
      end
      // Saturation check and divide setup
      ST_CHK: begin
        nfull = NW'(prod_q) << SH;
        ntop  = nfull[NW-1:GW];
        sat_q <= CW'(ntop) >= CW'(DIVISOR);
        dr_q  <= DVW'(ntop);
        nlo_q <= nfull[GW-1:0];
      end
      // Scale to g by restoring divide, one quotient bit a cycle
      ST_QDIV: begin
        dtry = {dr_q, nlo_q[GW-1]};
        if (dtry >= {1'b0, DIVISOR}) begin
          dr_q  <= DVW'(dtry - {1'b0, DIVISOR});
          nlo_q <= {nlo_q[GW-2:0], 1'b1};
        end else begin
          dr_q  <= dtry[DVW-1:0];
          nlo_q <= {nlo_q[GW-2:0], 1'b0};
        end
      end
      // Add magnitude to the weighted average and set up the divide
      ST_EADD: begin
        magv  = sat_q ? GMAX : nlo_q;
        mag_q <= magv;
        en    = ema_p_q + {WeightW'(0), magv};
        er_q  <= {1'b0, en[EPW-1:GW]};
        nlo_q <= en[GW-1:0];
      end
      // Divide by weight plus one, one quotient bit a cycle
      ST_EDIV: begin
        dvs  = {2'b00, weight_q} + (WeightW + 2)'(1);
        etry = {er_q, nlo_q[GW-1]};
        if (etry >= dvs) begin
          er_q  <= (WeightW + 1)'(etry - dvs);
          nlo_q <= {nlo_q[GW-2:0], 1'b1};
        end else begin
          er_q  <= etry[WeightW:0];
          nlo_q <= {nlo_q[GW-2:0], 1'b0};
        end
      end
      // Hand the result to the output register
      ST_DONE: begin
        if (out_load) begin
          out_q.magnitude_g     <= mag_q;
          out_q.averaged_g      <= nlo_q;
          out_q.motion_detected <= det;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQR))
    else $error("accepted request did not start the sequencer");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (above_q != 2'd2) && (above_q != 2'd3))
    else $error("above count reached detect value without clearing");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside the done step");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> out_valid_o)
    else $error("sequencer finished without presenting a result");

endmodule

FILE: bench/tb_accel_magnitude_ema_motion_detect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_magnitude_ema_motion_detect_top
// Drives accelerometer frames through the motion detector, models magnitude,
// moving average and detect flag per frame, and checks every result in order.
// Sender and receiver idle at random, with a long receiver hold-off once.
// ----------------------------------------------------------------------------
module tb_accel_magnitude_ema_motion_detect_top;
  import amemd_pkg::*;

  localparam int unsigned FracBits   = FracBitsDef;
  localparam int unsigned FracShift  = FracBits - 15;
  localparam logic [63:0] PicoG      = 64'd1000000000000;
  localparam logic [GW-1:0] GMax     = {GW{1'b1}};
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned FramesPerPhase = 110;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned DrainWait  = 130;
  localparam longint unsigned CycleLimit = 1000000;

  // Sensitivity per count in 1e-12 g, indexed by range
  localparam logic [3:0][31:0] SensPg = {32'd469483568, 32'd234741784,
                                         32'd117370892, 32'd58688890};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Predictor state and register copies
  logic [RangeW-1:0] cfg_range;
  logic [WeightW-1:0] cfg_weight;
  logic [GW-1:0] cfg_thresh;
  logic [GW-1:0] ema_avg;
  logic [1:0] above_run;

  in_t frame_queue[$];
  out_t pending_results[$];
  int unsigned fail_cnt = 0;
  bit no_idle = 1'b0;

  accel_magnitude_ema_motion_detect_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Integer square root, digit by digit
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] rem, res, probe;
    rem = n;
    res = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Magnitude in Q5.16 g for a given range, saturated to 21 bits
  function automatic logic [GW-1:0] frame_magnitude(input in_t f, input logic [RangeW-1:0] rng);
    logic signed [63:0] x, y, z;
    logic [63:0] sum_sq, root, prod, quo, rem, mag;
    x = f.accel_x;
    y = f.accel_y;
    z = f.accel_z;
    sum_sq = x * x + y * y + z * z;
    root = int_sqrt(sum_sq << 30);
    prod = root * {32'd0, SensPg[rng]};
    quo = prod / PicoG;
    rem = prod % PicoG;
    mag = (quo << FracShift) + ((rem << FracShift) / PicoG);
    return (mag > {43'd0, GMax}) ? GMax : mag[GW-1:0];
  endfunction

  // Advance the average and the above count, queue the expected result
  task automatic predict_frame(input in_t f);
    out_t want;
    logic [63:0] acc;
    want.magnitude_g = frame_magnitude(f, cfg_range);
    acc = ({43'd0, ema_avg} * {56'd0, cfg_weight} + {43'd0, want.magnitude_g})
          / ({56'd0, cfg_weight} + 64'd1);
    ema_avg = acc[GW-1:0];
    if (ema_avg > cfg_thresh) above_run = above_run + 2'd1;
    else above_run = 2'd0;
    want.motion_detected = 1'b0;
    if (above_run == 2'd2) begin
      above_run = 2'd0;
      want.motion_detected = 1'b1;
    end
    want.averaged_g = ema_avg;
    pending_results.push_back(want);
  endtask

  function automatic logic [AccelW-1:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[AccelW-1:0];
  endfunction

  function automatic int noise(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [AccelW-1:0] corner_axis();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Random frame: at rest, shaking, fully random or at the corners
  function automatic in_t make_frame(input logic [RangeW-1:0] rng);
    in_t f;
    int one_g, kind;
    one_g = 17039 >> rng;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      f.accel_x = 16'($urandom);
      f.accel_y = 16'($urandom);
      f.accel_z = 16'($urandom);
    end else if (kind < 6) begin
      f.accel_x = clip16(noise(one_g / 8));
      f.accel_y = clip16(noise(one_g / 8));
      f.accel_z = clip16((($urandom_range(0, 3) == 0) ? -one_g : one_g) + noise(one_g / 8));
    end else if (kind < 9) begin
      f.accel_x = clip16(noise(one_g * 3));
      f.accel_y = clip16(noise(one_g * 3));
      f.accel_z = clip16(noise(one_g * 3));
    end else begin
      f.accel_x = corner_axis();
      f.accel_y = corner_axis();
      f.accel_z = corner_axis();
    end
    return f;
  endfunction

  task automatic queue_frame(input int x, input int y, input int z);
    in_t f;
    f.accel_x = x[AccelW-1:0];
    f.accel_y = y[AccelW-1:0];
    f.accel_z = z[AccelW-1:0];
    frame_queue.push_back(f);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RANGE:  cfg_range = data[RangeW-1:0];
      REG_WEIGHT: cfg_weight = data[WeightW-1:0];
      REG_THRESH: cfg_thresh = data[GW-1:0];
      default: ;
    endcase
  endtask

  // Hold until every queued request is accepted and every result is back;
  // sample at the falling edge so the driver's updates have settled
  task automatic drain();
    while (frame_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] junk_high(input int unsigned low, input int w);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'($urandom);
    d = (d >> w) << w;
    return d | CfgDataW'(low);
  endfunction

  // Request side: offer queued frames, wait a random gap after each accept
  int unsigned gap_left = 0;
  bit gap_on_ready = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin : feed_frames
    logic holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left = 0;
      gap_on_ready = 1'b0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_frame(in_data_i);
        holding = 1'b0;
        gap_left = no_idle ? 0 : $urandom_range(0, 16);
        gap_on_ready = 1'($urandom_range(0, 1));
      end
      if (!holding) begin
        if (gap_left != 0) begin
          if (!gap_on_ready || in_ready_o) gap_left = gap_left - 1;
        end else if (frame_queue.size() != 0) begin
          in_data_i <= frame_queue.pop_front();
          holding = 1'b1;
        end
      end
      in_valid_i <= holding;
    end
  end

  task automatic check_field(input string field, input logic [GW-1:0] want,
                             input logic [GW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_cnt++;
    end
  endtask

  // Result side: check each result, stall at random, hold off once for long
  int unsigned stall_left = 0;
  int unsigned results_seen = 0;
  always @(posedge clk_i or negedge rst_ni) begin : collect_results
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      results_seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %p",
                   $time, out_data_o);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("magnitude_g", want.magnitude_g, out_data_o.magnitude_g);
          check_field("averaged_g", want.averaged_g, out_data_o.averaged_g);
          check_field("motion_detected", GW'(want.motion_detected),
                      GW'(out_data_o.motion_detected));
        end
        if (results_seen == HoldAfter) stall_left = HoldCycles;
        else stall_left = no_idle ? 0 : $urandom_range(0, 16);
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // Drop the run if it hangs
  longint unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int ph, n;
    logic [RangeW-1:0] rng;
    logic [WeightW-1:0] wgt;
    logic [GW-1:0] thr;
    in_t probe_frame;

    rst_ni = 1'b0;
    cfg_range = 2'd2;
    cfg_weight = 8'd10;
    cfg_thresh = GW'(1 << FracBits);
    ema_avg = GW'((9 * (1 << FracBits) + 5) / 10);
    above_run = 2'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes at reset settings, then a hard shake to trip the detector
    queue_frame(0, 0, 0);
    queue_frame(32767, 32767, 32767);
    queue_frame(-32768, -32768, -32768);
    queue_frame(-32768, 0, 0);
    queue_frame(0, 32767, 0);
    queue_frame(0, 0, -32768);
    queue_frame(1, -1, 1);
    queue_frame(-1, -1, -1);
    queue_frame(0, 0, 4260);
    repeat (4) queue_frame(12000, 12000, 12000);
    drain();

    // Zero weight and an average exactly at the threshold
    write_reg(REG_WEIGHT, junk_high(0, WeightW));
    write_reg(REG_RANGE, junk_high(0, RangeW));
    write_reg(RegSpare, CfgDataW'($urandom));
    probe_frame.accel_x = 16'sd1000;
    probe_frame.accel_y = -16'sd2000;
    probe_frame.accel_z = 16'sd16000;
    write_reg(REG_THRESH, frame_magnitude(probe_frame, cfg_range));
    queue_frame(20000, 0, 0);
    frame_queue.push_back(probe_frame);
    queue_frame(20000, 0, 0);
    queue_frame(20000, 0, 0);
    frame_queue.push_back(probe_frame);
    frame_queue.push_back(probe_frame);
    queue_frame(0, 20000, 0);
    frame_queue.push_back(probe_frame);
    drain();

    // Random phases, each with its own register settings
    for (ph = 0; ph < NumPhases; ph++) begin
      rng = RangeW'(ph % 4);
      case (ph)
        2:       wgt = 8'd255;
        3:       wgt = 8'd1;
        5:       wgt = 8'd0;
        7:       wgt = WeightW'($urandom_range(1, 255));
        default: wgt = WeightW'($urandom_range(1, 24));
      endcase
      case (ph)
        0:       thr = '0;
        1:       thr = GMax;
        default: thr = frame_magnitude(make_frame(rng), rng);
      endcase
      no_idle = (ph % 3 == 2);
      write_reg(REG_RANGE, junk_high(rng, RangeW));
      write_reg(REG_WEIGHT, junk_high(wgt, WeightW));
      write_reg(REG_THRESH, thr);
      write_reg(RegSpare, CfgDataW'($urandom));
      for (n = 0; n < FramesPerPhase; n++) frame_queue.push_back(make_frame(rng));
      drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/amemd_pkg.sv
hdl/accel_magnitude_ema_motion_detect_top.sv
bench/tb_accel_magnitude_ema_motion_detect_top.sv
